// ===== rtl/cppe_pkg.sv =====
package cppe_pkg;

    localparam int unsigned ADDR_W    = 24;
    localparam int unsigned ROW_W     = 10;
    localparam int unsigned HEIGHT_W  = 11;
    localparam int unsigned CFG_AW    = 4;
    localparam int unsigned CFG_DW    = 32;
    localparam int unsigned NUM_SLOTS = 11;
    localparam int unsigned SLOT_W    = 4;

    localparam logic [7:0]          MAX_RUN        = 8'd240;
    localparam logic [ROW_W-1:0]    LAST_START_ROW = 10'd252;
    localparam logic [7:0]          COLUMN_END     = 8'd255;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX     = 11'd1024;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_COLUMN_HEIGHT      = 2'd0;
    localparam logic [1:0] REG_TRANSPARENT_ENABLE = 2'd1;
    localparam logic [1:0] REG_TRANSPARENT_INDEX  = 2'd2;
    localparam logic [1:0] REG_DATA_BASE          = 2'd3;

    // result slots of one request, in emission order
    localparam logic [SLOT_W-1:0] SLOT_REPORT     = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_C1_START   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_C1_LENGTH  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_C1_TOP     = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_C1_BOTTOM  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_PIXEL      = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_C2_START   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_C2_LENGTH  = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_C2_TOP     = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_C2_BOTTOM  = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_END        = 4'd10;

    typedef struct packed {
        logic [HEIGHT_W-1:0] column_height;
        logic                transparent_enable;
        logic [7:0]          transparent_index;
        logic [ADDR_W-1:0]   data_base;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [7:0]        start_row;
        logic [7:0]        length;
        logic [7:0]        top_pad;
        logic [7:0]        bottom_pad;
    } close_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [ADDR_W-1:0]    report_value;
        close_t               close1;
        logic [ADDR_W-1:0]    pixel_address;
        logic [7:0]           pixel;
        close_t               close2;
        logic [ADDR_W-1:0]    end_address;
    } desc_t;

endpackage

// ===== rtl/cppe_front.sv =====
module cppe_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cppe_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          pixel,
    input  logic                                first_of_patch,
    output logic                                push,
    output cppe_pkg::desc_t                     push_desc,
    input  logic                                queue_ready
);
    import cppe_pkg::*;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic              active_reg, active_next;
    logic [7:0]        start_reg, start_next;
    logic [7:0]        length_reg, length_next;
    logic              kept_reg, kept_next;
    logic [7:0]        top_reg, top_next;
    logic [7:0]        bottom_reg, bottom_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;

    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    row0;
    logic [ADDR_W-1:0]   wp0, wp1, wp2;
    logic                active0, active1, transp, run_full, closes1, c1_en, c2_en, end_col;
    logic                take;

    assign in_ready = queue_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        if (cfg.column_height == '0) begin
            height = HEIGHT_W'(1);
        end else if (cfg.column_height > HEIGHT_MAX) begin
            height = HEIGHT_MAX;
        end else begin
            height = cfg.column_height;
        end

        wp0     = first_of_patch ? '0 : wp_reg;
        row0    = first_of_patch ? '0 : row_reg;
        active0 = first_of_patch ? 1'b0 : active_reg;

        transp   = cfg.transparent_enable && (pixel == cfg.transparent_index);
        run_full = length_reg >= MAX_RUN;
        closes1  = active0 && (transp || run_full);
        c1_en    = closes1 && kept_reg;
        wp1      = c1_en ? base_reg + ADDR_W'(4) + ADDR_W'(length_reg) : wp0;
        active1  = active0 && !closes1;

        start_next  = start_reg;
        length_next = length_reg;
        kept_next   = kept_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        base_next   = base_reg;
        active_next = active1;
        push_desc   = '0;

        if (!transp) begin
            // open a new run unless one carries on
            if (!active1) begin
                start_next  = row0[7:0];
                length_next = '0;
                kept_next   = row0 <= LAST_START_ROW;
                top_next    = pixel;
                base_next   = wp1;
            end
            push_desc.mask[SLOT_PIXEL] = kept_next;
            push_desc.pixel_address    = base_next + ADDR_W'(3) + ADDR_W'(length_next);
            push_desc.pixel            = pixel;
            bottom_next = pixel;
            length_next = length_next + 8'd1;
            active_next = 1'b1;
        end

        end_col = ({1'b0, row0} + HEIGHT_W'(1)) >= height;
        c2_en   = end_col && active_next && kept_next;
        wp2     = c2_en ? base_next + ADDR_W'(4) + ADDR_W'(length_next) : wp1;

        if (end_col) begin
            wp_next     = wp2 + ADDR_W'(1);
            row_next    = '0;
            active_next = 1'b0;
        end else begin
            wp_next  = wp2;
            row_next = row0 + ROW_W'(1);
        end

        push_desc.mask[SLOT_REPORT] = row0 == '0;
        push_desc.report_value      = cfg.data_base + wp0;

        push_desc.mask[SLOT_C1_START]  = c1_en;
        push_desc.mask[SLOT_C1_LENGTH] = c1_en;
        push_desc.mask[SLOT_C1_TOP]    = c1_en;
        push_desc.mask[SLOT_C1_BOTTOM] = c1_en;
        push_desc.close1 = '{base: base_reg, start_row: start_reg, length: length_reg,
                             top_pad: top_reg, bottom_pad: bottom_reg};

        push_desc.mask[SLOT_C2_START]  = c2_en;
        push_desc.mask[SLOT_C2_LENGTH] = c2_en;
        push_desc.mask[SLOT_C2_TOP]    = c2_en;
        push_desc.mask[SLOT_C2_BOTTOM] = c2_en;
        push_desc.close2 = '{base: base_next, start_row: start_next, length: length_next,
                             top_pad: top_next, bottom_pad: bottom_next};

        push_desc.mask[SLOT_END] = end_col;
        push_desc.end_address    = wp2;
    end

    // a pixel with no result pushes nothing
    assign push = take && (push_desc.mask != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            active_reg <= 1'b0;
            start_reg  <= '0;
            length_reg <= '0;
            kept_reg   <= 1'b0;
            top_reg    <= '0;
            bottom_reg <= '0;
            base_reg   <= '0;
            wp_reg     <= '0;
        end else if (take) begin
            row_reg    <= row_next;
            active_reg <= active_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            kept_reg   <= kept_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            base_reg   <= base_next;
            wp_reg     <= wp_next;
        end
    end

    a_kept_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg && kept_reg |-> {2'b00, start_reg} <= LAST_START_ROW)
        else $error("kept run starts below the last start row");

    a_run_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> length_reg <= MAX_RUN && length_reg != '0)
        else $error("open run length out of range");

endmodule

// ===== rtl/cppe_queue.sv =====
module cppe_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = store_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != CW'(DEPTH))
        else $error("request pushed into a full queue");

endmodule

// ===== rtl/cppe_back.sv =====
module cppe_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  cppe_pkg::desc_t                     q_desc,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                kind,
    output logic [cppe_pkg::ADDR_W-1:0]         address,
    output logic [7:0]                          data_byte,
    output logic                                last
);
    import cppe_pkg::*;

    desc_t                desc_reg, desc_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [SLOT_W-1:0]    slot;
    logic                 advance, load;

    // lowest pending slot goes out first
    always_comb begin
        slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                slot = SLOT_W'(i);
            end
        end
    end

    assign out_valid = mask_reg != '0;
    assign last      = (mask_reg & (mask_reg - NUM_SLOTS'(1))) == '0;
    assign advance   = out_valid && out_ready;
    assign load      = !out_valid || (advance && last);
    assign q_pop     = load && q_valid;

    always_comb begin
        kind      = 1'b0;
        address   = '0;
        data_byte = '0;
        unique case (slot)
            SLOT_REPORT: begin
                kind    = 1'b1;
                address = desc_reg.report_value;
            end
            SLOT_C1_START: begin
                address   = desc_reg.close1.base;
                data_byte = desc_reg.close1.start_row;
            end
            SLOT_C1_LENGTH: begin
                address   = desc_reg.close1.base + ADDR_W'(1);
                data_byte = desc_reg.close1.length;
            end
            SLOT_C1_TOP: begin
                address   = desc_reg.close1.base + ADDR_W'(2);
                data_byte = desc_reg.close1.top_pad;
            end
            SLOT_C1_BOTTOM: begin
                address   = desc_reg.close1.base + ADDR_W'(3)
                            + ADDR_W'(desc_reg.close1.length);
                data_byte = desc_reg.close1.bottom_pad;
            end
            SLOT_PIXEL: begin
                address   = desc_reg.pixel_address;
                data_byte = desc_reg.pixel;
            end
            SLOT_C2_START: begin
                address   = desc_reg.close2.base;
                data_byte = desc_reg.close2.start_row;
            end
            SLOT_C2_LENGTH: begin
                address   = desc_reg.close2.base + ADDR_W'(1);
                data_byte = desc_reg.close2.length;
            end
            SLOT_C2_TOP: begin
                address   = desc_reg.close2.base + ADDR_W'(2);
                data_byte = desc_reg.close2.top_pad;
            end
            SLOT_C2_BOTTOM: begin
                address   = desc_reg.close2.base + ADDR_W'(3)
                            + ADDR_W'(desc_reg.close2.length);
                data_byte = desc_reg.close2.bottom_pad;
            end
            SLOT_END: begin
                address   = desc_reg.end_address;
                data_byte = COLUMN_END;
            end
            default: begin
                kind      = 1'b0;
                address   = '0;
                data_byte = '0;
            end
        endcase
    end

    always_comb begin
        desc_next = desc_reg;
        mask_next = mask_reg;
        if (load) begin
            desc_next = q_desc;
            mask_next = q_valid ? q_desc.mask : '0;
        end else if (advance) begin
            mask_next = mask_reg & (mask_reg - NUM_SLOTS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> mask_reg == $past(mask_reg))
        else $error("pending slots changed while the receiver stalls");

    a_one_slot_per_take: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !last |=> $countones(mask_reg) == $countones($past(mask_reg)) - 1)
        else $error("more than one slot retired per result");

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !out_valid || (out_ready && last))
        else $error("request loaded over pending results");

endmodule

// ===== rtl/column_post_patch_encoder.sv =====
// column post encoder for palette patch images
//
// s_ channel: one palette pixel per request (s_pixel, s_first_of_patch),
// column after column, each column already tiled to column_height rows.
// m_ channel: results, one per cycle at most; m_kind 1 reports a column's
// start offset, m_kind 0 is a byte write at m_address in the post data.
// m_last marks the final result caused by one pixel. a pixel with no result
// (transparent, no open run, not a column's first or last row) produces
// nothing on m_. the front stage takes one pixel per cycle while the queue
// has room and turns it into a bundle of up to ten results; a small queue
// (QUEUE_DEPTH bundles) feeds the back stage, which sends one result per
// cycle while m_ready is high. throughput is therefore one pixel per cycle
// while pixels give one result each; pixels with more results slow intake
// once the queue fills. when m_ready is low results hold and the queue
// fills, then s_ready drops. synchronous reset clears the run state, the
// queue and the output, and loads the register defaults (height 128,
// transparency off, index 247, data base 1032). the user must write the
// registers over the APB port while idle; the block does not enforce it.
module column_post_patch_encoder #(
    parameter int unsigned QUEUE_DEPTH = cppe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cppe_pkg::CFG_AW-1:0]    paddr,
    input  logic [cppe_pkg::CFG_DW-1:0]    pwdata,
    output logic [cppe_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_pixel,
    input  logic                           s_first_of_patch,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_kind,
    output logic [cppe_pkg::ADDR_W-1:0]    m_address,
    output logic [7:0]                     m_data_byte,
    output logic                           m_last
);
    import cppe_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [1:0] reg_index;

    logic  push, queue_ready, q_valid, q_pop;
    desc_t push_desc, q_desc;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.column_height      <= HEIGHT_W'(128);
            cfg_reg.transparent_enable <= 1'b0;
            cfg_reg.transparent_index  <= 8'd247;
            cfg_reg.data_base          <= ADDR_W'(1032);
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_COLUMN_HEIGHT:      cfg_reg.column_height <= pwdata[HEIGHT_W-1:0];
                REG_TRANSPARENT_ENABLE: cfg_reg.transparent_enable <= pwdata[0];
                REG_TRANSPARENT_INDEX:  cfg_reg.transparent_index <= pwdata[7:0];
                REG_DATA_BASE:          cfg_reg.data_base <= pwdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_COLUMN_HEIGHT:      prdata = CFG_DW'(cfg_reg.column_height);
            REG_TRANSPARENT_ENABLE: prdata = CFG_DW'(cfg_reg.transparent_enable);
            REG_TRANSPARENT_INDEX:  prdata = CFG_DW'(cfg_reg.transparent_index);
            REG_DATA_BASE:          prdata = CFG_DW'(cfg_reg.data_base);
            default:                prdata = '0;
        endcase
    end

    cppe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .pixel          (s_pixel),
        .first_of_patch (s_first_of_patch),
        .push           (push),
        .push_desc      (push_desc),
        .queue_ready    (queue_ready)
    );

    cppe_queue #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_desc),
        .push_ready (queue_ready),
        .pop        (q_pop),
        .pop_data   (q_desc),
        .pop_valid  (q_valid)
    );

    cppe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_desc    (q_desc),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .kind      (m_kind),
        .address   (m_address),
        .data_byte (m_data_byte),
        .last      (m_last)
    );

endmodule

// ===== bench/tb_column_post_patch_encoder.sv =====
module tb_column_post_patch_encoder;
    import cppe_pkg::*;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] pixel;
        logic       first;
        int         gap;
        bit         drain;
    } pixel_req_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic              last;
    } post_write_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_pixel = '0;
    logic                s_first_of_patch = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_kind;
    logic [ADDR_W-1:0]   m_address;
    logic [7:0]          m_data_byte;
    logic                m_last;

    // register shadow, reset values of the block
    logic [HEIGHT_W-1:0] cfg_height = 11'd128;
    logic                cfg_trans_en = 1'b0;
    logic [7:0]          cfg_trans_idx = 8'd247;
    logic [ADDR_W-1:0]   cfg_base = 24'd1032;

    // encoder state
    logic [ROW_W-1:0]    enc_row = '0;
    logic                enc_open = 1'b0;
    logic [ROW_W-1:0]    enc_start_row = '0;
    logic [7:0]          enc_len = '0;
    logic                enc_kept = 1'b0;
    logic [7:0]          enc_top = '0;
    logic [7:0]          enc_bottom = '0;
    logic [ADDR_W-1:0]   enc_base = '0;
    logic [ADDR_W-1:0]   enc_wptr = '0;

    pixel_req_t          pending_pixels[$];
    post_write_t         pixel_bundle[$];
    post_write_t         expected_writes[$];

    int pixels_queued = 0;
    int pixels_taken = 0;
    int errors = 0;
    int tx_gap_max = 11;
    int rx_gap_max = 11;
    int tx_wait = 0;
    int rx_wait = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    column_post_patch_encoder DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .s_first_of_patch (s_first_of_patch),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_address        (m_address),
        .m_data_byte      (m_data_byte),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function void emit_write(logic kind, logic [ADDR_W-1:0] addr, logic [7:0] data);
        post_write_t w;
        w.kind = kind;
        w.address = addr;
        w.data_byte = data;
        w.last = 1'b0;
        pixel_bundle.insert(pixel_bundle.size(), w);
    endfunction

    // header and pads go out only when the post closes
    function void close_post();
        if (enc_open && enc_kept) begin
            emit_write(KIND_WRITE, enc_base, enc_start_row[7:0]);
            emit_write(KIND_WRITE, enc_base + 24'd1, enc_len);
            emit_write(KIND_WRITE, enc_base + 24'd2, enc_top);
            emit_write(KIND_WRITE, enc_base + 24'd3 + {16'd0, enc_len}, enc_bottom);
            enc_wptr = enc_base + 24'd4 + {16'd0, enc_len};
        end
        enc_open = 1'b0;
    endfunction

    function void encode_pixel(logic [7:0] pix, logic first);
        int height;
        height = int'(cfg_height);
        if (height == 0) height = 1;
        if (height > int'(HEIGHT_MAX)) height = int'(HEIGHT_MAX);
        pixel_bundle.delete();
        if (first) begin
            enc_wptr = '0;
            enc_row = '0;
            enc_open = 1'b0;
        end
        if (enc_row == '0) emit_write(KIND_REPORT, cfg_base + enc_wptr, 8'd0);
        if (cfg_trans_en && pix == cfg_trans_idx) begin
            close_post();
        end else begin
            if (enc_open && enc_len >= MAX_RUN) close_post();
            if (!enc_open) begin
                enc_open = 1'b1;
                enc_start_row = enc_row;
                enc_len = '0;
                enc_kept = (enc_row <= LAST_START_ROW);
                enc_top = pix;
                enc_base = enc_wptr;
            end
            if (enc_kept) emit_write(KIND_WRITE, enc_base + 24'd3 + {16'd0, enc_len}, pix);
            enc_bottom = pix;
            enc_len = enc_len + 8'd1;
        end
        if (int'(enc_row) + 1 >= height) begin
            close_post();
            emit_write(KIND_WRITE, enc_wptr, COLUMN_END);
            enc_wptr = enc_wptr + 24'd1;
            enc_row = '0;
        end else begin
            enc_row = enc_row + 1'b1;
        end
        if (pixel_bundle.size() > 0) pixel_bundle[pixel_bundle.size() - 1].last = 1'b1;
        foreach (pixel_bundle[i]) expected_writes.insert(expected_writes.size(), pixel_bundle[i]);
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (pending_pixels.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_pixels[0].drain && (s_valid || expected_writes.size() != 0)) begin
                // hold back until the block has emptied
                s_valid <= 1'b0;
            end else if (tx_wait < pending_pixels[0].gap) begin
                s_valid <= 1'b0;
                tx_wait <= tx_wait + 1;
            end else begin
                s_valid <= 1'b1;
                s_pixel <= pending_pixels[0].pixel;
                s_first_of_patch <= pending_pixels[0].first;
                void'(pending_pixels.pop_front());
                tx_wait <= 0;
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin : drive_ready
        int draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else if (m_valid && m_ready) begin
            draw = $urandom_range(0, rx_gap_max);
            rx_wait <= draw;
            m_ready <= (draw == 0);
        end else if (!m_ready) begin
            if (rx_wait > 1) begin
                rx_wait <= rx_wait - 1;
            end else begin
                rx_wait <= 0;
                m_ready <= 1'b1;
            end
        end
    end

    // prediction on each request, then comparison of each result
    always @(posedge aclk) begin : watch_results
        post_write_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_pixel(s_pixel, s_first_of_patch);
                pixels_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("result with nothing expected: kind %0d address %h byte %h",
                           m_kind, m_address, m_data_byte);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("m_kind: expected %0d, got %0d", want.kind, m_kind);
                        errors++;
                    end
                    if (m_address !== want.address) begin
                        $error("m_address: expected %h, got %h", want.address, m_address);
                        errors++;
                    end
                    if (m_data_byte !== want.data_byte) begin
                        $error("m_data_byte: expected %h, got %h", want.data_byte, m_data_byte);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last: expected %0d, got %0d", want.last, m_last);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void queue_pixel(logic [7:0] pix, logic first, bit drain);
        pixel_req_t req;
        req.pixel = pix;
        req.first = first;
        req.gap = $urandom_range(0, tx_gap_max);
        req.drain = drain;
        pending_pixels.insert(pending_pixels.size(), req);
        pixels_queued++;
    endfunction

    task automatic settle();
        do @(negedge aclk);
        while (pixels_taken != pixels_queued || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COLUMN_HEIGHT:      cfg_height = val[HEIGHT_W-1:0];
            REG_TRANSPARENT_ENABLE: cfg_trans_en = val[0];
            REG_TRANSPARENT_INDEX:  cfg_trans_idx = val[7:0];
            REG_DATA_BASE:          cfg_base = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        int h;
        int pick;
        int hole_pct;
        logic [7:0] pix;
        logic first;
        bit hole;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: transparency off, so index 247 is an ordinary pixel
        queue_pixel(8'd247, 1'b1, 1'b0);
        queue_pixel(8'h00, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        settle();

        // height 0 acts as 1 and ends the open column at once; base wraps
        reg_write(REG_COLUMN_HEIGHT, 32'd0);
        reg_write(REG_TRANSPARENT_ENABLE, 32'd1);
        reg_write(REG_TRANSPARENT_INDEX, 32'd0);
        reg_write(REG_DATA_BASE, 32'h00FF_FFFE);
        queue_pixel(8'h00, 1'b0, 1'b0);
        queue_pixel(8'h00, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        settle();

        // holes, a hole with no open post, new patch with a post still open
        reg_write(REG_COLUMN_HEIGHT, 32'd6);
        reg_write(REG_TRANSPARENT_INDEX, 32'hFF);
        queue_pixel(8'h12, 1'b1, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'h80, 1'b0, 1'b0);
        queue_pixel(8'h7F, 1'b0, 1'b0);
        queue_pixel(8'h01, 1'b1, 1'b0);
        queue_pixel(8'h02, 1'b0, 1'b0);
        queue_pixel(8'h03, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'h04, 1'b0, 1'b0);
        settle();

        // height lowered below the current row mid-column
        reg_write(REG_COLUMN_HEIGHT, 32'd10);
        queue_pixel(8'h11, 1'b0, 1'b0);
        queue_pixel(8'h22, 1'b0, 1'b0);
        queue_pixel(8'h33, 1'b0, 1'b0);
        settle();
        reg_write(REG_COLUMN_HEIGHT, 32'd2);
        queue_pixel(8'h44, 1'b0, 1'b0);
        settle();

        // long column: post split at the length limit, post starting on the
        // last allowed row, a dropped post below it closed by the column end
        reg_write(REG_COLUMN_HEIGHT, 32'd255);
        reg_write(REG_TRANSPARENT_INDEX, $urandom_range(0, 255));
        reg_write(REG_DATA_BASE, $urandom);
        tx_gap_max = 0;
        rx_gap_max = 0;
        for (int row = 0; row < 255; row++) begin
            pix = 8'($urandom);
            if (pix == cfg_trans_idx) pix = pix ^ 8'h01;
            if (row == 251 || row == 253) pix = cfg_trans_idx;
            queue_pixel(pix, row == 0, 1'b0);
        end
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) h = $urandom_range(1, 8);
            else if (pick < 17) h = $urandom_range(9, 40);
            else if (pick == 17) h = 0;
            else h = $urandom_range(1025, 2047);
            reg_write(REG_COLUMN_HEIGHT, h);
            reg_write(REG_TRANSPARENT_ENABLE, $urandom_range(0, 1));
            reg_write(REG_TRANSPARENT_INDEX, $urandom_range(0, 255));
            reg_write(REG_DATA_BASE, $urandom);
            hole_pct = $urandom_range(0, 3) * 20;
            tx_gap_max = (phase % 3 == 2) ? 0 : 11;
            rx_gap_max = (phase % 3 == 1) ? 0 : 11;
            if (phase == 1) begin
                // receiver stalls long while pixels keep coming
                tx_gap_max = 0;
                hole_pct = 0;
                hold_asked++;
            end
            for (int n = 0; n < ((phase == 1) ? 8 : 4); n++) begin
                first = (n == 0 && phase == 0) || ($urandom_range(0, 99) < 5);
                hole = cfg_trans_en && ($urandom_range(0, 99) < hole_pct);
                pix = hole ? cfg_trans_idx : 8'($urandom);
                queue_pixel(pix, first, (phase == 3 && n == 2) || ($urandom_range(0, 99) < 3));
            end
            settle();
        end

        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("tb_column_post_patch_encoder: clean");
        end else begin
            $display("tb_column_post_patch_encoder: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_column_post_patch_encoder: errors");
        $finish;
    end

endmodule
